/* rtl/qrm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and codes for the id queue with remove-by-id.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int QRM_DEPTH = 16;
  localparam int QRM_ID_W  = 8;

  localparam int CMD_W    = 2;
  localparam int PID_W    = 8;
  localparam int STATUS_W = 2;
  localparam int OUT_ID_W = 8;
  localparam int COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [OUT_ID_W-1:0] id;
    logic [COUNT_W-1:0]  count;
    logic                empty;
  } qrm_res_t;

endpackage

/* rtl/qrm_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qrm_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* rtl/qrm_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_seq
// Command sequencer: walks the store one entry a cycle through a single
// compare unit, then closes up the later entries one move a cycle.
// ----------------------------------------------------------------------------
module qrm_seq #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [qrm_pkg::CMD_W-1:0]       cmd,
  input  logic [qrm_pkg::PID_W-1:0]       pid,
  input  logic [ID_WIDTH-1:0]             rd_data,
  output logic [$clog2(QUEUE_DEPTH)-1:0]  rd_addr,
  output logic                            wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]  wr_addr,
  output logic [ID_WIDTH-1:0]             wr_data,
  output qrm_pkg::qrm_res_t               res
);
  import qrm_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    tag_r, tag_nxt;
  logic                chk_r, chk_nxt;
  logic                shift_r, shift_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic [ID_WIDTH-1:0] got_r, got_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                issue;
  logic                hit;

  assign busy  = (state_r != S_IDLE);
  assign issue = (idx_r < count_r);
  // dequeue always takes the head, remove needs an id match
  assign hit   = (cmd_r == CMD_DEQUEUE) || (rd_data == id_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    tag_nxt    = tag_r;
    chk_nxt    = chk_r;
    shift_nxt  = shift_r;
    cmd_nxt    = cmd_r;
    id_nxt     = id_r;
    got_nxt    = got_r;
    status_nxt = status_r;
    rd_addr    = idx_r[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = count_r[IDX_W-1:0];
    wr_data    = ID_WIDTH'(pid);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = cmd;
          id_nxt     = ID_WIDTH'(pid);
          got_nxt    = '0;
          idx_nxt    = '0;
          chk_nxt    = 1'b0;
          shift_nxt  = 1'b0;
          status_nxt = ST_DONE;
          state_nxt  = S_DONE;
          case (cmd)
            CMD_ENQUEUE: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DEQUEUE, CMD_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_ABSENT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              status_nxt = ST_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        chk_nxt = issue;
        tag_nxt = idx_r[IDX_W-1:0];
        if (issue) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (chk_r && !shift_r && hit) begin
          // restart reads just past the match, dropping the read in flight
          got_nxt   = (cmd_r == CMD_DEQUEUE) ? rd_data : '0;
          shift_nxt = 1'b1;
          idx_nxt   = CNT_W'(tag_r) + CNT_W'(1);
          chk_nxt   = 1'b0;
        end
        if (chk_r && shift_r) begin
          wr_en   = 1'b1;
          wr_addr = tag_r - IDX_W'(1);
          wr_data = rd_data;
        end
        if (!issue && !chk_r) begin
          state_nxt = S_DONE;
          if (shift_r) begin
            count_nxt  = count_r - CNT_W'(1);
            status_nxt = ST_DONE;
          end else begin
            status_nxt = ST_ABSENT;
          end
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      chk_r   <= 1'b0;
      shift_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      chk_r   <= chk_nxt;
      shift_r <= shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    tag_r    <= tag_nxt;
    cmd_r    <= cmd_nxt;
    id_r     <= id_nxt;
    got_r    <= got_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    res.valid  = (state_r == S_DONE);
    res.status = status_r;
    res.id     = OUT_ID_W'(got_r);
    res.count  = COUNT_W'(count_r);
    res.empty  = (count_r == '0);
  end

endmodule

/* rtl/fifo_queue_with_remove_by_id.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id
// Bounded queue of process ids with enqueue, dequeue and remove-by-id.
// ----------------------------------------------------------------------------
// A request (in_command, in_process_id) is taken at a clock edge where start
// is high and busy is low. Commands: enqueue at tail, dequeue head, remove the
// first entry holding the given id (later entries close up in order).
// Each request gives one result, shown for a single cycle with out_valid:
// out_status, out_id (head id on dequeue, else zero), out_count_after and
// out_is_empty. The receiver cannot stall, so results are never held.
// Enqueue, unknown codes and requests on an empty queue go from idle
// straight to the done state, whose result passes through the output register.
// Dequeue and remove walk the entry memory one entry a cycle through one
// compare unit, then move each later entry down one slot a cycle. busy
// stays high until the last cycle before the result leaves, so requests
// are taken one at a time.
// Reset empties the queue; memory contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_id #(
  parameter int QUEUE_DEPTH = qrm_pkg::QRM_DEPTH,
  parameter int ID_WIDTH    = qrm_pkg::QRM_ID_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [qrm_pkg::CMD_W-1:0]      in_command,
  input  logic [qrm_pkg::PID_W-1:0]      in_process_id,
  output logic                           out_valid,
  output logic [qrm_pkg::STATUS_W-1:0]   out_status,
  output logic [qrm_pkg::OUT_ID_W-1:0]   out_id,
  output logic [qrm_pkg::COUNT_W-1:0]    out_count_after,
  output logic                           out_is_empty
);
  import qrm_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [ID_WIDTH-1:0] wr_data;
  logic [IDX_W-1:0]    rd_addr;
  logic [ID_WIDTH-1:0] rd_data_r;
  qrm_res_t            res_nxt;
  qrm_res_t            res_r;

  qrm_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .cmd     (in_command),
    .pid     (in_process_id),
    .rd_data (rd_data_r),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res     (res_nxt)
  );

  qrm_store #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_WIDTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  // result register on the output side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_r.valid;
  assign out_status      = res_r.status;
  assign out_id          = res_r.id;
  assign out_count_after = res_r.count;
  assign out_is_empty    = res_r.empty;

endmodule

/* rtl/qrm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrm_checker
// Port-level checks for the id queue, bound to the top level.
// ----------------------------------------------------------------------------
module qrm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [qrm_pkg::STATUS_W-1:0] out_status,
  input logic [qrm_pkg::OUT_ID_W-1:0] out_id,
  input logic [qrm_pkg::COUNT_W-1:0]  out_count_after,
  input logic                         out_is_empty
);
  import qrm_pkg::*;

  // an accepted request holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low right after an accepted request");

  // busy drops exactly as the result leaves
  a_result_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy released without a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_count_after == '0)
    else $error("empty flag with nonzero count");

  // only a successful dequeue returns an id
  a_id_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_id != '0) |-> out_status == ST_DONE)
    else $error("id returned with failure status");

endmodule

bind fifo_queue_with_remove_by_id qrm_checker u_qrm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_id          (out_id),
  .out_count_after (out_count_after),
  .out_is_empty    (out_is_empty)
);
